// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CNGH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on the block's own clock and reset.
`define CNGH_ASSERT_CLK(lbl, prop, msg) \
  `CNGH_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- design/cngh_pkg.sv -----
// ----------------------------------------------------------------------------
// cngh_pkg
// Types and constants of the character n-gram bucket hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package cngh_pkg;

  // Register indexes
  localparam logic [1:0] REG_MIN_LEN = 2'd0;
  localparam logic [1:0] REG_MAX_LEN = 2'd1;
  localparam logic [1:0] REG_BUCKETS = 2'd2;

  localparam logic [2:0]  MIN_LEN_RST = 3'd3;
  localparam logic [2:0]  MAX_LEN_RST = 3'd6;
  localparam logic [24:0] BUCKETS_RST = 25'd2000000;

  localparam logic [2:0] GRAM_FLOOR = 3'd2;
  localparam logic [2:0] GRAM_CEIL  = 3'd6;

  // FNV-1a 64: prime = 2^40 + 435
  localparam logic [63:0] FNV_BASIS  = 64'hCBF29CE484222325;
  localparam logic [8:0]  FNV_PR_LO  = 9'd435;
  localparam int          FNV_PR_SHL = 40;

  localparam logic [7:0] OPEN_MARK  = 8'h3C;
  localparam logic [7:0] CLOSE_MARK = 8'h3E;

  // Position width: framed word is at most 14 bytes
  localparam int POS_W = 5;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_word;
  } in_beat_t;

  typedef struct packed {
    logic [23:0] bucket_index;
    logic [2:0]  gram_length;
    logic        no_ngrams;
    logic        word_truncated;
    logic        last_result;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic             store_en;
    logic             word_clear;
    logic             hash_init;
    logic             hash_step;
    logic [POS_W-1:0] pos;
    logic             mod_init;
    logic             mod_step;
    logic             out_load;
    logic [2:0]       out_len;
    logic             out_empty;
    logic             out_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [POS_W-1:0] flen;
    logic [2:0]       lo;
    logic [2:0]       hi;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/cngh_dp.sv -----
// ----------------------------------------------------------------------------
// cngh_dp
// Datapath: config registers, word store, FNV-1a hash, bit-serial modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module cngh_dp #(
  parameter int MAX_WORD_BYTES = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [24:0]      cfg_wdata_i,
  input  wire cngh_pkg::in_beat_t in_data_i,
  input  wire cngh_pkg::cmd_t   cmd_i,
  output cngh_pkg::stat_t       stat_o,
  output cngh_pkg::out_beat_t   out_data_o
);

  localparam int IDX_W = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
  localparam int PW    = cngh_pkg::POS_W;
  localparam logic [PW-1:0] DEPTH = PW'(MAX_WORD_BYTES);

  logic [2:0]  min_q, max_q;
  logic [24:0] bkt_q;
  logic [7:0]  store_q [MAX_WORD_BYTES];
  logic [PW-1:0] len_q;
  logic        ovf_q;
  logic [63:0] hash_q, hash_d;
  logic [24:0] rem_q, rem_d;
  cngh_pkg::out_beat_t out_q;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= cngh_pkg::MIN_LEN_RST;
      max_q <= cngh_pkg::MAX_LEN_RST;
      bkt_q <= cngh_pkg::BUCKETS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cngh_pkg::REG_MIN_LEN: min_q <= cfg_wdata_i[2:0];
        cngh_pkg::REG_MAX_LEN: max_q <= cfg_wdata_i[2:0];
        cngh_pkg::REG_BUCKETS: bkt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Word capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.word_clear) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.store_en) begin
      if (len_q < DEPTH) len_q <= len_q + 1'b1;
      else               ovf_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en && len_q < DEPTH) store_q[len_q[IDX_W-1:0]] <= in_data_i.char_byte;
  end

  assign stat_o.flen = len_q + PW'(2);
  assign stat_o.lo   = (min_q < cngh_pkg::GRAM_FLOOR) ? cngh_pkg::GRAM_FLOOR : min_q;
  assign stat_o.hi   = (max_q > cngh_pkg::GRAM_CEIL) ? cngh_pkg::GRAM_CEIL : max_q;

  // Framed byte select
  logic [7:0]    fbyte;
  logic [PW-1:0] sidx;
  assign sidx = cmd_i.pos - 1'b1;
  always_comb begin
    if (cmd_i.pos == '0)                    fbyte = cngh_pkg::OPEN_MARK;
    else if (cmd_i.pos + 1'b1 >= stat_o.flen) fbyte = cngh_pkg::CLOSE_MARK;
    else                                    fbyte = store_q[sidx[IDX_W-1:0]];
  end

  // One FNV-1a round per step; during modulo the hash shifts out MSB first
  logic [63:0] hx;
  logic [25:0] rsh;
  logic [24:0] modulus;
  assign hx      = hash_q ^ {{56{fbyte[7]}}, fbyte};
  assign modulus = (bkt_q == '0) ? 25'd1 : bkt_q;
  assign rsh     = {rem_q, hash_q[63]};

  always_comb begin
    hash_d = hash_q;
    rem_d  = rem_q;
    if (cmd_i.hash_init) hash_d = cngh_pkg::FNV_BASIS;
    else if (cmd_i.hash_step)
      hash_d = (hx << cngh_pkg::FNV_PR_SHL) + hx * cngh_pkg::FNV_PR_LO;
    else if (cmd_i.mod_step) begin
      hash_d = {hash_q[62:0], 1'b0};
      // remainder stays below the modulus, so 25 bits hold it
      rem_d  = (rsh >= {1'b0, modulus}) ? 25'(rsh - {1'b0, modulus}) : rsh[24:0];
    end
    if (cmd_i.mod_init) rem_d = '0;
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    rem_q  <= rem_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.bucket_index   <= cmd_i.out_empty ? 24'd0 : rem_q[23:0];
      out_q.gram_length    <= cmd_i.out_len;
      out_q.no_ngrams      <= cmd_i.out_empty;
      out_q.word_truncated <= ovf_q;
      out_q.last_result    <= cmd_i.out_last;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- design/cngh_ctrl.sv -----
// ----------------------------------------------------------------------------
// cngh_ctrl
// Sequencer: load bytes, walk n-gram lengths and starts, pace hash and modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module cngh_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_eow_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire cngh_pkg::stat_t stat_i,
  output cngh_pkg::cmd_t      cmd_o
);

  localparam int PW = cngh_pkg::POS_W;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_HASH  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]    st_q, st_d;
  logic [2:0]    n_q, n_d;
  logic [PW-1:0] i_q, i_d;
  logic [2:0]    j_q, j_d;
  logic [5:0]    b_q, b_d;
  logic          last_q, last_d;

  logic [PW-1:0] nx, end_next;
  logic          is_last;
  assign nx       = PW'(n_q);
  assign end_next = i_q + nx + 1'b1;
  assign is_last  = (end_next > stat_i.flen) &&
                    ((n_q == stat_i.hi) || (nx + 1'b1 > stat_i.flen));

  always_comb begin
    st_d   = st_q;
    n_d    = n_q;
    i_d    = i_q;
    j_d    = j_q;
    b_d    = b_q;
    last_d = last_q;
    cmd_o  = '0;
    cmd_o.pos     = i_q + PW'(j_q);
    cmd_o.out_len = n_q;
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    case (st_q)
      S_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.store_en = 1'b1;
          if (in_eow_i) st_d = S_SETUP;
        end
      end
      // Set up the first n-gram length; if nothing fits, emit the empty marker
      S_SETUP: begin
        n_d = stat_i.lo;
        i_d = '0;
        if (stat_i.lo > stat_i.hi || PW'(stat_i.lo) > stat_i.flen) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_empty = 1'b1;
          cmd_o.out_len   = 3'd0;
          cmd_o.out_last  = 1'b1;
          last_d = 1'b1;
          st_d   = S_OUT;
        end else begin
          st_d = S_START;
        end
      end
      S_START: begin
        cmd_o.hash_init = 1'b1;
        j_d  = '0;
        st_d = S_HASH;
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        j_d = j_q + 1'b1;
        if (j_q == n_q - 1'b1) begin
          cmd_o.mod_init = 1'b1;
          b_d  = '0;
          st_d = S_MOD;
        end
      end
      // 64 restoring steps, one dividend bit each
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        b_d = b_q + 1'b1;
        if (b_q == 6'd63) st_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = is_last;
        last_d = is_last;
        st_d   = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (last_q) begin
            cmd_o.word_clear = 1'b1;
            st_d = S_LOAD;
          end else begin
            if (end_next <= stat_i.flen) begin
              i_d = i_q + 1'b1;
            end else begin
              n_d = n_q + 1'b1;
              i_d = '0;
            end
            st_d = S_START;
          end
        end
      end
      default: st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_LOAD;
      n_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      b_q    <= '0;
      last_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      n_q    <= n_d;
      i_q    <= i_d;
      j_q    <= j_d;
      b_q    <= b_d;
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/char_ngram_bucket_hasher_top.sv -----
// ----------------------------------------------------------------------------
// char_ngram_bucket_hasher_top
// Subword n-gram hasher: FNV-1a 64 of each framed n-gram, reduced to a bucket.
// ----------------------------------------------------------------------------
// A word is taken one byte beat per cycle while the input is not stalled; the
// beat with end_of_word starts emission. The word first passes a setup state;
// each n-gram then runs through a start state, a hash round per character, the
// bit-serial modulo unit, a load state and an output state. The restoring
// divider produces one quotient bit per cycle. New bytes are stalled during
// emission.
`default_nettype none
`include "assert_macros.svh"

module char_ngram_bucket_hasher_top #(
  parameter int MAX_WORD_BYTES = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [24:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire cngh_pkg::in_beat_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output cngh_pkg::out_beat_t       out_data_o
);

  cngh_pkg::cmd_t  cmd;
  cngh_pkg::stat_t stat;

  cngh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_eow_i    (in_data_i.end_of_word),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cngh_dp #(
    .MAX_WORD_BYTES (MAX_WORD_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  // Terms for the checks below
  logic empty_beat, empty_shape, last_fire;
  assign empty_beat  = out_valid_o && out_data_o.no_ngrams;
  assign empty_shape = out_data_o.last_result && (out_data_o.gram_length == 3'd0);
  assign last_fire   = out_valid_o && !out_stall_i && out_data_o.last_result;

  // No byte is taken while a result is pending
  `CNGH_ASSERT_CLK(a_stall_on_out, out_valid_o |-> in_stall_o, "input open during emit")
  // Empty marker always closes the word
  `CNGH_ASSERT_CLK(a_empty_last, empty_beat |-> empty_shape, "bad empty marker")
  // Final beat of a word returns to loading
  `CNGH_ASSERT_CLK(a_last_done, last_fire |=> (!out_valid_o && !in_stall_o), "no return to load")

endmodule

`default_nettype wire

// ----- verif/tb_char_ngram_bucket_hasher_top.sv -----
// ----------------------------------------------------------------------------
// tb_char_ngram_bucket_hasher_top
// Self-checking bench: byte beats in, predicted n-gram bucket beats compared.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_char_ngram_bucket_hasher_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_CAP = 12;
  localparam longint unsigned CYCLE_LIMIT = 64'd3000000;
  localparam logic [1:0] REG_NONE = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [24:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  cngh_pkg::in_beat_t  in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  cngh_pkg::out_beat_t out_data_o;

  char_ngram_bucket_hasher_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Predictor state
  logic [7:0]  word_bytes [WORD_CAP];
  int          word_len;
  bit          word_overflow;
  logic [2:0]  min_len_q;
  logic [2:0]  max_len_q;
  logic [24:0] buckets_q;

  cngh_pkg::in_beat_t  byte_queue [$];
  cngh_pkg::out_beat_t bucket_queue [$];
  int        errors;
  bit        send_idle_ok;
  bit        recv_idle_ok;
  bit        in_fire;
  int        hold_cycles;
  longint unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] framed_at(int pos, int flen);
    if (pos == 0) return cngh_pkg::OPEN_MARK;
    if (pos + 1 >= flen) return cngh_pkg::CLOSE_MARK;
    return word_bytes[pos-1];
  endfunction

  // Model one accepted byte beat; queue any bucket beats it causes
  task automatic predict_beat(cngh_pkg::in_beat_t b);
    int flen, lo, hi, count;
    logic [63:0] h, modv, widened;
    logic [7:0] c;
    cngh_pkg::out_beat_t r;
    if (word_len < WORD_CAP) begin
      word_bytes[word_len] = b.char_byte;
      word_len++;
    end else word_overflow = 1'b1;
    if (!b.end_of_word) return;
    flen = word_len + 2;
    lo = (min_len_q < 2) ? 2 : min_len_q;
    hi = (max_len_q > 6) ? 6 : max_len_q;
    modv = (buckets_q == 0) ? 64'd1 : 64'(buckets_q);
    count = 0;
    for (int n = lo; n <= hi; n++) begin
      for (int i = 0; i + n <= flen; i++) begin
        h = 64'hCBF29CE484222325;
        for (int j = 0; j < n; j++) begin
          c = framed_at(i + j, flen);
          widened = {{56{c[7]}}, c};
          h = (h ^ widened) * 64'd1099511628211;
        end
        r.bucket_index = 24'(h % modv);
        r.gram_length = 3'(n);
        r.no_ngrams = 1'b0;
        r.word_truncated = word_overflow;
        r.last_result = 1'b0;
        bucket_queue = {bucket_queue, r};
        count++;
      end
    end
    if (count == 0) begin
      r = '0;
      r.no_ngrams = 1'b1;
      r.word_truncated = word_overflow;
      r.last_result = 1'b1;
      bucket_queue = {bucket_queue, r};
    end else bucket_queue[$].last_result = 1'b1;
    word_len = 0;
    word_overflow = 1'b0;
  endtask

  // Driver: beats change on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_fire) begin
      // hold stalled beat
    end else if (byte_queue.size() != 0 &&
                 (!send_idle_ok || $urandom_range(99) >= 36)) begin
      in_valid_i <= 1'b1;
      in_data_i  <= byte_queue.pop_front();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else
      out_stall_i <= recv_idle_ok && ($urandom_range(99) < 36);
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (in_valid_i && !in_stall_o) predict_beat(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (bucket_queue.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual %p", $time, out_data_o);
          errors++;
        end else begin
          if (bucket_queue[0] !== out_data_o) begin
            $display("%0t: mismatch, expected %p actual %p", $time,
                     bucket_queue[0], out_data_o);
            errors++;
          end
          void'(bucket_queue.pop_front());
        end
      end
    end
  end

  // Run guard
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL char_ngram_bucket_hasher_top");
      $finish;
    end
  end

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_valid_i || bucket_queue.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [24:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cngh_pkg::REG_MIN_LEN: min_len_q = val[2:0];
      cngh_pkg::REG_MAX_LEN: max_len_q = val[2:0];
      cngh_pkg::REG_BUCKETS: buckets_q = val;
      default: ;
    endcase
  endtask

  task automatic push_word(int len, bit printable);
    cngh_pkg::in_beat_t b;
    for (int k = 0; k < len; k++) begin
      b.char_byte = printable ? 8'($urandom_range(97, 122)) : 8'($urandom);
      b.end_of_word = (k == len - 1);
      byte_queue = {byte_queue, b};
    end
  endtask

  task automatic push_fixed(logic [7:0] v, int len);
    cngh_pkg::in_beat_t b;
    for (int k = 0; k < len; k++) begin
      b.char_byte = v;
      b.end_of_word = (k == len - 1);
      byte_queue = {byte_queue, b};
    end
  endtask

  initial begin
    int budget;
    errors = 0; cycle_count = 0; hold_cycles = 0;
    send_idle_ok = 1'b0; recv_idle_ok = 1'b0;
    word_len = 0; word_overflow = 1'b0;
    min_len_q = cngh_pkg::MIN_LEN_RST;
    max_len_q = cngh_pkg::MAX_LEN_RST;
    buckets_q = cngh_pkg::BUCKETS_RST;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: reset settings, extremes of byte values, truncation
    push_fixed(8'h00, 1);
    push_fixed(8'hFF, 3);
    push_fixed(8'h80, 12);
    push_fixed(8'h7F, 14);
    wait_drained();

    // Widest range, full store, huge and unit modulus
    write_reg(cngh_pkg::REG_MIN_LEN, 25'd0);
    write_reg(cngh_pkg::REG_MAX_LEN, 25'd7);
    write_reg(cngh_pkg::REG_BUCKETS, 25'h1FFFFFF);
    push_word(12, 1'b0);
    push_word(2, 1'b0);
    wait_drained();
    write_reg(cngh_pkg::REG_BUCKETS, 25'd0);
    push_word(4, 1'b0);
    wait_drained();
    write_reg(cngh_pkg::REG_BUCKETS, 25'd1);
    write_reg(REG_NONE, 25'd5);   // unmapped index, ignored
    push_word(3, 1'b1);
    wait_drained();

    // Nothing fits: inverted range, and long grams on a short word; then a word that fits one gram
    write_reg(cngh_pkg::REG_MIN_LEN, 25'd5);
    write_reg(cngh_pkg::REG_MAX_LEN, 25'd3);
    push_word(3, 1'b1);
    wait_drained();
    write_reg(cngh_pkg::REG_MIN_LEN, 25'd6);
    write_reg(cngh_pkg::REG_MAX_LEN, 25'd6);
    push_word(1, 1'b0);
    push_word(4, 1'b0);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering beats
    write_reg(cngh_pkg::REG_MIN_LEN, 25'd2);
    write_reg(cngh_pkg::REG_MAX_LEN, 25'd2);
    write_reg(cngh_pkg::REG_BUCKETS, 25'd1000);
    hold_cycles = 400;
    push_word(3, 1'b1);
    push_word(5, 1'b1);
    push_word(2, 1'b1);
    wait_drained();

    // Random phases with random settings and idling
    send_idle_ok = 1'b1; recv_idle_ok = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(cngh_pkg::REG_MIN_LEN, 25'($urandom_range(7)));
      write_reg(cngh_pkg::REG_MAX_LEN, 25'($urandom_range(7)));
      write_reg(cngh_pkg::REG_BUCKETS,
                (ph % 2) ? 25'($urandom) : 25'($urandom_range(1, 5000)));
      budget = 18;
      while (budget > 0) begin
        int wl;
        wl = ($urandom_range(9) == 0) ? $urandom_range(13, 15) : $urandom_range(1, 6);
        push_word(wl, 1'($urandom_range(1)));
        budget -= wl;
      end
      wait_drained();
    end

    wait_drained();
    if (errors == 0) $display("PASS char_ngram_bucket_hasher_top");
    else $display("FAIL char_ngram_bucket_hasher_top");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+design
design/cngh_pkg.sv
design/cngh_dp.sv
design/cngh_ctrl.sv
design/char_ngram_bucket_hasher_top.sv
verif/tb_char_ngram_bucket_hasher_top.sv
